// ----- rtl/core/bdd5_pkg.sv -----
// Package for the 5x5 diamond binary dilation block: shared constants and types.
// Depends on nothing; the top level imports it.
package bdd5_pkg;

    // Structuring element size and the number of stored rows above the current one.
    localparam int KERNEL_SIZE = 5;
    localparam int LINE_COUNT  = KERNEL_SIZE - 1;

    // Size registers reset to this many columns and rows, clamped to the build maximum.
    localparam int RESET_SIZE = 1024;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 2'd1;

    // Input command codes.
    typedef logic command_t;

    localparam command_t CMD_PIXEL = 1'b0;
    localparam command_t CMD_FLUSH = 1'b1;

    // Output buffer.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Control carried from the accept stage to the line store stage.
    typedef struct packed {
        logic                  valid;
        logic                  out;
        logic                  last;
        logic                  pix;
        logic [LINE_COUNT-1:0] rmask;
        logic [3:0]            cmask;
    } s1_ctrl_t;

    typedef struct packed {
        logic pixel;
        logic last;
    } result_t;

endpackage

// ----- rtl/core/binary_dilation_diamond5_top.sv -----
// Top level of the streaming 5x5 diamond binary dilation block.
// Depends on bdd5_pkg; holds the line store memory, the tap window and the output buffer.
//
// Usage:
// Pixels enter on the input channel in raster order (command, pixel_in), one request per
// clock at most. The dilated image leaves on the output channel (pixel_out, frame_last)
// in the same order; frame_last marks the final pixel of the image. After the W*H image
// pixels the source sends 2W+2 flush requests, which push out the last outputs.
// Output k belongs to input request k+2W+2. It enters the output buffer at the edge after
// that request is accepted, and out_valid is high while it waits there. The block sustains one
// request per cycle while the output buffer has room; the figure is set by the line store, a
// single memory with one read and one write port that is read at each request and written
// back in the following cycle.
// The configuration channel writes image_width (index 0) and image_height (index 1);
// a write to either restarts the frame. Writes belong between frames, when nothing is
// in flight.
// At reset the counters clear and the size is 1024 by 1024 (clamped to the maximum).
// The line store is not cleared: rows above the top of the image are masked, so stale
// contents are never seen. When the receiver stalls, up to four results wait in the
// output buffer and the input channel drops ready once that buffer could overflow.
module binary_dilation_diamond5_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic                               pixel_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               pixel_out,
    output logic                               frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  bdd5_pkg::cfg_index_t               cfg_index,
    input  logic [bdd5_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bdd5_pkg::*;

    // Column address, size register, input row, warm-up counter widths.
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HH = $clog2(MAX_HEIGHT + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 4);
    localparam int LW = $clog2(2 * MAX_WIDTH + 3);
    localparam int W_RESET = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
    localparam int H_RESET = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

    // Size registers, held already clamped.
    logic [WW-1:0] w_reg, w_next;
    logic [HH-1:0] h_reg, h_next;
    logic          cfg_fire;
    logic          cfg_hit;

    // Position counters of the accept stage.
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [LW-1:0] lag_reg, lag_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [HH-1:0] out_row_reg, out_row_next;

    logic          in_fire;
    logic          col_last;
    logic [LW-1:0] lag_target;
    logic          out_en;
    logic          frame_end;
    logic          pix_ok;
    s1_ctrl_t      s1_next;
    s1_ctrl_t      s1_reg;
    logic [AW-1:0] s1_col_reg;

    // Line store: for each column, the pixels of the four rows above the newest one.
    logic [LINE_COUNT-1:0] row_mem [MAX_WIDTH];
    logic [LINE_COUNT-1:0] line_rd_reg;
    logic [LINE_COUNT-1:0] fwd_data_reg;
    logic                  fwd_hit_reg;
    logic [LINE_COUNT-1:0] line_now;
    logic [LINE_COUNT-1:0] line_wdata;
    logic [KERNEL_SIZE-1:0] col_vec;

    // Column vectors of the four previous requests; entry 0 is the most recent.
    logic [KERNEL_SIZE-1:0] win_reg [LINE_COUNT];
    logic                   dilated;

    // Output buffer.
    result_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic [FIFO_AW:0]     occupancy;
    logic                 push;
    logic                 pop;

    // ------------------------------------------------------------------
    // Configuration. Zero acts as one and values above the maximum are clamped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_comb
    begin
        w_next  = w_reg;
        h_next  = h_reg;
        cfg_hit = 1'b0;
        if (cfg_fire)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data == '0)
                        w_next = WW'(1);
                    else if (32'(cfg_data) > MAX_WIDTH)
                        w_next = WW'(MAX_WIDTH);
                    else
                        w_next = WW'(cfg_data);
                end
                REG_IMAGE_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data == '0)
                        h_next = HH'(1);
                    else if (32'(cfg_data) > MAX_HEIGHT)
                        h_next = HH'(MAX_HEIGHT);
                    else
                        h_next = HH'(cfg_data);
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: positions, masks and the line store read.
    // ------------------------------------------------------------------
    assign in_fire    = in_valid & in_ready;
    assign col_last   = (WW'(in_col_reg) == (w_reg - WW'(1)));
    assign lag_target = (LW'(w_reg) << 1) + LW'(2);
    // Outputs start once 2W+2 requests of the frame have been taken.
    assign out_en     = (lag_reg >= lag_target);
    assign frame_end  = out_en && (WW'(out_col_reg) == (w_reg - WW'(1)))
                        && (out_row_reg == (h_reg - HH'(1)));
    // Anything at or beyond the end of the image enters the store as a zero.
    assign pix_ok     = (command == CMD_PIXEL) && (in_row_reg < HW'(h_reg));

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        lag_next     = lag_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit || (in_fire && frame_end))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            lag_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (in_fire)
        begin
            if (col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
            if (!out_en)
                lag_next = lag_reg + LW'(1);
            if (out_en)
            begin
                if (WW'(out_col_reg) == (w_reg - WW'(1)))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HH'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        s1_next       = '0;
        s1_next.valid = in_fire;
        s1_next.out   = out_en;
        s1_next.last  = frame_end;
        s1_next.pix   = pix_ok ? pixel_in : 1'b0;
        // Stored row j above the current one exists only when the current row exceeds j.
        for (int j = 0; j < LINE_COUNT; j++)
            s1_next.rmask[j] = (in_row_reg > HW'(j));
        // Horizontal neighbours of the output column that lie inside the image.
        s1_next.cmask[0] = (out_col_reg >= AW'(2));
        s1_next.cmask[1] = (out_col_reg != '0);
        s1_next.cmask[2] = ((WW+1)'(out_col_reg) + (WW+1)'(1)) < (WW+1)'(w_reg);
        s1_next.cmask[3] = ((WW+1)'(out_col_reg) + (WW+1)'(2)) < (WW+1)'(w_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= WW'(W_RESET);
            h_reg       <= HH'(H_RESET);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            lag_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_reg      <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            lag_reg     <= lag_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_reg      <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_col_reg <= in_col_reg;
    end

    // ------------------------------------------------------------------
    // Line store. Read at accept, written back in the following cycle. When the
    // request behind hits the column being written (narrow images), the
    // written value is forwarded in place of the stale read.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
            row_mem[s1_col_reg] <= line_wdata;
        if (in_fire)
        begin
            line_rd_reg  <= row_mem[in_col_reg];
            fwd_hit_reg  <= s1_reg.valid && (s1_col_reg == in_col_reg);
            fwd_data_reg <= line_wdata;
        end
    end

    assign line_now   = fwd_hit_reg ? fwd_data_reg : line_rd_reg;
    assign line_wdata = {line_now[LINE_COUNT-2:0], s1_reg.pix};
    // Bit 0 is the newest row; bit 2 is the row of the output pixel.
    assign col_vec    = {line_now & s1_reg.rmask, s1_reg.pix};

    // ------------------------------------------------------------------
    // Tap window. The centre column is two requests back; the diamond takes
    // the full centre column, three rows of the adjacent columns and the
    // middle row of the outer columns.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            win_reg[0] <= col_vec;
            for (int i = 1; i < LINE_COUNT; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

    assign dilated = (|win_reg[1])
                   | (s1_reg.cmask[2] & (|win_reg[0][3:1]))
                   | (s1_reg.cmask[1] & (|win_reg[2][3:1]))
                   | (s1_reg.cmask[3] & col_vec[2])
                   | (s1_reg.cmask[0] & win_reg[3][2]);

    // ------------------------------------------------------------------
    // Output buffer. Ready is withheld when the buffer plus the result in
    // flight could not take one more.
    // ------------------------------------------------------------------
    assign push      = s1_reg.valid & s1_reg.out;
    assign pop       = out_valid & out_ready;
    assign occupancy = cnt_reg + (FIFO_AW+1)'(push);
    assign in_ready  = (occupancy < (FIFO_AW+1)'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign pixel_out  = fifo_reg[rd_ptr_reg].pixel;
    assign frame_last = fifo_reg[rd_ptr_reg].last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + FIFO_AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + (FIFO_AW+1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].pixel <= dilated;
            fifo_reg[wr_ptr_reg].last  <= s1_reg.last;
        end
    end

endmodule
